FILE: rtl/core/sfdr_pkg.sv
// Shared types and constants of the sync frame deframer and router.
`default_nettype none

package sfdr_pkg;

	localparam int CNT_W      = 17;
	localparam int LEN_W      = 16;
	localparam int MASK_W     = 4;
	localparam int ROUTE_REGS = 4;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [7:0] SYNC_A = 8'h55;
	localparam logic [7:0] SYNC_B = 8'hAA;

	localparam logic [CNT_W-1:0] HDR_LEN = CNT_W'(8);
	localparam logic [CNT_W-1:0] CRC_LEN = CNT_W'(2);

	localparam logic [7:0]       IDLE_LIMIT_RST  = 8'd2;
	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd4086;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	localparam logic [REG_IDX_W-1:0] REG_IDLE_LIMIT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FILT0       = 3'd2;

	typedef struct packed {
		logic       en;
		logic [7:0] app_id;
		logic [7:0] msg_lo;
		logic [7:0] msg_hi;
	} route_filter_t;

	typedef struct packed {
		logic [7:0]                        idle_tick_limit;
		logic [LEN_W-1:0]                  max_payload;
		route_filter_t [ROUTE_REGS-1:0]    route_filter;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfdr_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface sfdr_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sfdr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [16:0] byte_offset;
	logic        byte_valid;
	logic        frame_last;
	logic        frame_abort;
	logic [15:0] payload_length;
	logic [3:0]  route_mask;

	modport source (output valid, output out_byte, output byte_offset, output byte_valid,
		output frame_last, output frame_abort, output payload_length, output route_mask,
		input ready);
	modport sink (input valid, input out_byte, input byte_offset, input byte_valid,
		input frame_last, input frame_abort, input payload_length, input route_mask,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sfdr_cfg_regs.sv
// APB-style configuration register file of the deframer.
`default_nettype none

module sfdr_cfg_regs
	import sfdr_pkg::*;
#(
	parameter int NUM_ROUTES = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	localparam int NUM_FILT = (NUM_ROUTES < ROUTE_REGS) ? NUM_ROUTES : ROUTE_REGS;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic [7:0]           idle_limit_q;
	logic [LEN_W-1:0]     max_payload_q;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q  <= IDLE_LIMIT_RST;
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (wr_en) begin
			if (reg_idx == REG_IDLE_LIMIT) begin
				idle_limit_q <= pwdata[7:0];
			end
			if (reg_idx == REG_MAX_PAYLOAD) begin
				max_payload_q <= pwdata[LEN_W-1:0];
			end
		end
	end

	assign cfg.idle_tick_limit = idle_limit_q;
	assign cfg.max_payload     = max_payload_q;

	// Filters past the configured route count are not stored and read as disabled.
	for (genvar i = 0; i < ROUTE_REGS; i++) begin : g_filt
		if (i < NUM_FILT) begin : g_store
			route_filter_t filt_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					filt_q <= '0;
				end else if (wr_en && reg_idx == REG_IDX_W'(REG_FILT0 + i)) begin
					filt_q <= route_filter_t'(pwdata[$bits(route_filter_t)-1:0]);
				end
			end

			assign cfg.route_filter[i] = filt_q;
		end else begin : g_none
			assign cfg.route_filter[i] = '0;
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_IDLE_LIMIT:  prdata = PDATA_W'(idle_limit_q);
			REG_MAX_PAYLOAD: prdata = PDATA_W'(max_payload_q);
			default: begin
				if (reg_idx >= REG_FILT0 && reg_idx < REG_IDX_W'(REG_FILT0 + ROUTE_REGS)) begin
					prdata = PDATA_W'(cfg.route_filter[2'(reg_idx - REG_FILT0)]);
				end
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/sfdr_route_match.sv
// Route filter comparators: one mask bit per matching enabled filter.
`default_nettype none

module sfdr_route_match
	import sfdr_pkg::*;
(
	input  wire cfg_t               cfg,
	input  wire logic [7:0]         app_id,
	input  wire logic [7:0]         msg_id,
	output logic      [MASK_W-1:0]  mask
);

	always_comb begin
		mask = '0;
		for (int i = 0; i < ROUTE_REGS; i++) begin
			mask[i] = cfg.route_filter[i].en
				&& cfg.route_filter[i].app_id == app_id
				&& msg_id >= cfg.route_filter[i].msg_lo
				&& msg_id <= cfg.route_filter[i].msg_hi;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sfdr_core.sv
// Deframer datapath: input register, frame state, decode logic and result register.
`default_nettype none

module sfdr_core
	import sfdr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	sfdr_in_if.sink    in_ch,
	sfdr_out_if.source out_ch
);

	// Input register
	logic       valid_s1;
	logic       opcode_s1;
	logic [7:0] rx_byte_s1;

	// Frame state
	logic [CNT_W-1:0] byte_count_q;
	logic [LEN_W-1:0] length_hold_q;
	logic [7:0]       app_id_q;
	logic [7:0]       msg_id_q;
	logic [7:0]       len_high_q;
	logic [7:0]       idle_ticks_q;
	logic             activity_q;

	// Result register
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [CNT_W-1:0]  offset_q;
	logic              byte_valid_q;
	logic              last_q;
	logic              abort_q;
	logic [LEN_W-1:0]  len_q;
	logic [MASK_W-1:0] mask_q;

	logic              advance;
	logic              in_accept;

	logic [CNT_W-1:0]  cnt_n;
	logic [LEN_W-1:0]  len_hold_n;
	logic [7:0]        app_id_n;
	logic [7:0]        msg_id_n;
	logic [7:0]        len_high_n;
	logic [7:0]        idle_n;
	logic              activity_n;

	logic              res_valid;
	logic [7:0]        r_byte;
	logic [CNT_W-1:0]  r_off;
	logic              r_bvalid;
	logic              r_last;
	logic              r_abort;
	logic [LEN_W-1:0]  r_len;
	logic [MASK_W-1:0] r_mask;

	logic [MASK_W-1:0] match_mask;
	logic [7:0]        idle_inc;
	logic [LEN_W-1:0]  hdr_len;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  frame_end;

	sfdr_route_match u_match (
		.cfg    (cfg),
		.app_id (app_id_q),
		.msg_id (msg_id_q),
		.mask   (match_mask)
	);

	// The held item moves on when the result register is empty or being drained.
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_accept    = in_ch.valid && in_ch.ready;

	assign idle_inc  = idle_ticks_q + 8'd1;
	assign hdr_len   = {len_high_q, rx_byte_s1};
	assign cnt_inc   = byte_count_q + CNT_W'(1);
	assign frame_end = CNT_W'(length_hold_q) + HDR_LEN + CRC_LEN;

	always_comb begin
		cnt_n      = byte_count_q;
		len_hold_n = length_hold_q;
		app_id_n   = app_id_q;
		msg_id_n   = msg_id_q;
		len_high_n = len_high_q;
		idle_n     = idle_ticks_q;
		activity_n = activity_q;
		res_valid  = 1'b0;
		r_byte     = '0;
		r_off      = '0;
		r_bvalid   = 1'b0;
		r_last     = 1'b0;
		r_abort    = 1'b0;
		r_len      = '0;
		r_mask     = '0;

		if (opcode_s1 == OP_TICK) begin
			if (activity_q) begin
				activity_n = 1'b0;
				idle_n     = '0;
			end else if (byte_count_q != '0) begin
				if (idle_inc < cfg.idle_tick_limit) begin
					idle_n = idle_inc;
				end else begin
					cnt_n      = '0;
					len_hold_n = '0;
					idle_n     = '0;
					res_valid  = 1'b1;
					r_abort    = 1'b1;
				end
			end
		end else begin
			activity_n = 1'b1;
			res_valid  = 1'b1;
			if (byte_count_q == '0) begin
				if (rx_byte_s1 == SYNC_A) begin
					r_bvalid = 1'b1;
					r_byte   = rx_byte_s1;
					cnt_n    = CNT_W'(1);
				end
			end else if (byte_count_q == CNT_W'(1)) begin
				if (rx_byte_s1 == SYNC_B) begin
					r_bvalid = 1'b1;
					r_byte   = rx_byte_s1;
					r_off    = CNT_W'(1);
					cnt_n    = CNT_W'(2);
				end else begin
					// A fresh 0x55 restarts the frame in place of the broken one.
					r_abort = 1'b1;
					if (rx_byte_s1 == SYNC_A) begin
						r_bvalid = 1'b1;
						r_byte   = rx_byte_s1;
						cnt_n    = CNT_W'(1);
					end else begin
						cnt_n = '0;
					end
				end
			end else if (byte_count_q == HDR_LEN - CNT_W'(1)) begin
				r_len = hdr_len;
				if (hdr_len > cfg.max_payload) begin
					r_abort    = 1'b1;
					cnt_n      = '0;
					len_hold_n = '0;
				end else begin
					len_hold_n = hdr_len;
					r_bvalid   = 1'b1;
					r_byte     = rx_byte_s1;
					r_off      = byte_count_q;
					cnt_n      = HDR_LEN;
				end
			end else begin
				if (byte_count_q == CNT_W'(2)) begin
					app_id_n = rx_byte_s1;
				end
				if (byte_count_q == CNT_W'(3)) begin
					msg_id_n = rx_byte_s1;
				end
				if (byte_count_q == CNT_W'(5)) begin
					len_high_n = rx_byte_s1;
				end
				r_bvalid = 1'b1;
				r_byte   = rx_byte_s1;
				r_off    = byte_count_q;
				r_len    = (byte_count_q >= HDR_LEN) ? length_hold_q : '0;
				cnt_n    = cnt_inc;
				if (byte_count_q >= HDR_LEN && cnt_inc >= frame_end) begin
					r_last     = 1'b1;
					r_mask     = match_mask;
					cnt_n      = '0;
					len_hold_n = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_s1  <= in_ch.opcode;
			rx_byte_s1 <= in_ch.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			length_hold_q <= '0;
			app_id_q      <= '0;
			msg_id_q      <= '0;
			len_high_q    <= '0;
			idle_ticks_q  <= '0;
			activity_q    <= 1'b0;
		end else if (advance) begin
			byte_count_q  <= cnt_n;
			length_hold_q <= len_hold_n;
			app_id_q      <= app_id_n;
			msg_id_q      <= msg_id_n;
			len_high_q    <= len_high_n;
			idle_ticks_q  <= idle_n;
			activity_q    <= activity_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_byte_q   <= r_byte;
			offset_q     <= r_off;
			byte_valid_q <= r_bvalid;
			last_q       <= r_last;
			abort_q      <= r_abort;
			len_q        <= r_len;
			mask_q       <= r_mask;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.out_byte       = out_byte_q;
	assign out_ch.byte_offset    = offset_q;
	assign out_ch.byte_valid     = byte_valid_q;
	assign out_ch.frame_last     = last_q;
	assign out_ch.frame_abort    = abort_q;
	assign out_ch.payload_length = len_q;
	assign out_ch.route_mask     = mask_q;

endmodule

`default_nettype wire

FILE: rtl/core/sync_frame_deframer_router_top.sv
// Top level of the sync frame deframer and router.
//
//  Channel  Direction  Transaction                       Fields
//  in_ch    sink       one received byte or timer tick   opcode, rx_byte
//  out_ch   source     one per byte, one per abort tick  out_byte .. route_mask
//  apb      slave      register write or read            paddr, pwdata, prdata
//
// An accepted item is held in the input register and is then decoded into the result
// register, from which its result is offered; while the result side does not stall,
// one item is taken every cycle.
// The input register and result register decouple the two sides: a stalled result
// holds and the next item waits in the input register, after which input ready drops.
// Reset clears the frame state, the registers to their defaults and both valids.
`default_nettype none

module sync_frame_deframer_router_top
	import sfdr_pkg::*;
#(
	parameter int NUM_ROUTES = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	sfdr_in_if.sink                 in_ch,
	sfdr_out_if.source              out_ch,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	cfg_t cfg;

	sfdr_cfg_regs #(
		.NUM_ROUTES (NUM_ROUTES)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfdr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire
